/* rtl/gww_pkg.sv */
// Greedy word wrap: shared constants, character codes, step codes and the
// microcode table of the control sequencer. No dependencies.
package gww_pkg;

  localparam int MaxWord = 32;
  localparam int LenW    = $clog2(MaxWord + 1);
  localparam int AddrW   = (MaxWord > 1) ? $clog2(MaxWord) : 1;
  localparam int CharW   = 7;
  localparam int LineW   = 8;
  localparam int WleftW  = 10;

  localparam logic [CharW-1:0] CH_NUL = 7'd0;
  localparam logic [CharW-1:0] CH_TAB = 7'd9;
  localparam logic [CharW-1:0] CH_NL  = 7'd10;
  localparam logic [CharW-1:0] CH_SP  = 7'd32;

  localparam logic [LineW-1:0] RESET_WIDTH = 8'd23;

  // sequencer step codes
  localparam int PcW = 3;
  localparam logic [PcW-1:0] S_IDLE    = 3'd0;
  localparam logic [PcW-1:0] S_FIT     = 3'd1;
  localparam logic [PcW-1:0] S_LETTERS = 3'd2;
  localparam logic [PcW-1:0] S_SPACE   = 3'd3;
  localparam logic [PcW-1:0] S_NLOUT   = 3'd4;

  typedef enum logic [1:0] {OE_NONE, OE_ALWAYS, OE_WRAP} oe_e;
  typedef enum logic [1:0] {OSEL_NL, OSEL_LETTER, OSEL_SPACE} osel_e;
  typedef enum logic [1:0] {LAST_NO, LAST_YES, LAST_IF_NOT_NL} last_e;
  typedef enum logic [1:0] {WOP_HOLD, WOP_FIT, WOP_NUL_RELOAD, WOP_RELOAD} wop_e;
  typedef enum logic [2:0] {BR_DISPATCH, BR_NEXT, BR_LOOP, BR_NL_OR_IDLE, BR_IDLE} br_e;
  typedef enum logic [1:0] {IDX_HOLD, IDX_CLEAR, IDX_INC} idx_e;

  typedef struct packed {
    logic  fetch;
    oe_e   oe;
    osel_e osel;
    last_e last;
    wop_e  wop;
    idx_e  idx;
    logic  clr_word;
    br_e   br;
  } ctrl_t;

  function automatic ctrl_t ucode(logic [PcW-1:0] pc);
    ctrl_t w;
    w = '{fetch: 1'b1, oe: OE_NONE, osel: OSEL_NL, last: LAST_NO, wop: WOP_HOLD,
          idx: IDX_HOLD, clr_word: 1'b0, br: BR_DISPATCH};
    unique case (pc)
      S_FIT: begin
        w = '{fetch: 1'b0, oe: OE_WRAP, osel: OSEL_NL, last: LAST_NO, wop: WOP_FIT,
              idx: IDX_CLEAR, clr_word: 1'b0, br: BR_NEXT};
      end
      S_LETTERS: begin
        w = '{fetch: 1'b0, oe: OE_ALWAYS, osel: OSEL_LETTER, last: LAST_NO,
              wop: WOP_HOLD, idx: IDX_INC, clr_word: 1'b0, br: BR_LOOP};
      end
      S_SPACE: begin
        w = '{fetch: 1'b0, oe: OE_ALWAYS, osel: OSEL_SPACE, last: LAST_IF_NOT_NL,
              wop: WOP_NUL_RELOAD, idx: IDX_HOLD, clr_word: 1'b1, br: BR_NL_OR_IDLE};
      end
      S_NLOUT: begin
        w = '{fetch: 1'b0, oe: OE_ALWAYS, osel: OSEL_NL, last: LAST_YES,
              wop: WOP_RELOAD, idx: IDX_HOLD, clr_word: 1'b0, br: BR_IDLE};
      end
      default: begin
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/gww_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gww_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/greedy_word_wrap.sv */
// Greedy word wrap top level: microcoded sequencer, word store and output register.
// Depends on gww_pkg and gww_ram.
//
//  channel  | dir | handshake           | payload
//  s_axis   | in  | tvalid/tready       | tdata[6:0] in_char
//  m_axis   | out | tvalid/tready       | tdata[6:0] out_char, tlast last
//  cfg      | in  | we (no wait)        | wdata[7:0] line_width
//
// Letter, space or tab: idle step only. Word end: idle, fit, one letters step per
// letter (one store read each), space, and newline for an input newline; one result
// per cycle, unless the output stalls. Newline alone: idle step, then newline step.
// Reset: line width and remaining width 23, no word held. Output stalls
// freeze the sequencer on any step that emits a request.
module greedy_word_wrap
  import gww_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [6:0] in_char
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [6:0] out_char
  output logic       m_axis_tlast_o,   // last
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i       // line_width
);

  logic [PcW-1:0]           pc_q, pc_d;
  logic [CharW-1:0]         char_q, char_d;
  logic [LenW-1:0]          wlen_q, wlen_d;
  logic [LenW-1:0]          idx_q, idx_d;
  logic                     in_word_q, in_word_d;
  logic signed [WleftW-1:0] wleft_q, wleft_d;
  logic [LineW-1:0]         lw_q;
  logic                     out_vld_q, out_vld_d;
  logic [CharW-1:0]         out_char_q, out_char_d;
  logic                     out_last_q, out_last_d;

  ctrl_t                    cw;
  logic [CharW-1:0]         in_char;
  logic                     accept, is_delim, wrap, emit, go;
  logic signed [WleftW-1:0] len_ext, len_p1, lw_ext;
  logic                     ram_we;
  logic [LenW-1:0]          rd_idx;
  logic [CharW-1:0]         ram_rdata;

  assign cw       = ucode(pc_q);
  assign in_char  = s_axis_tdata_i[CharW-1:0];
  assign is_delim = (in_char == CH_NUL) || (in_char == CH_SP) ||
                    (in_char == CH_TAB) || (in_char == CH_NL);
  assign s_axis_tready_o = cw.fetch;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;

  assign len_ext = $signed({{(WleftW-LenW){1'b0}}, wlen_q});
  assign len_p1  = len_ext + WleftW'(1);
  assign lw_ext  = $signed({{(WleftW-LineW){1'b0}}, lw_q});
  assign wrap    = len_p1 > wleft_q;

  assign emit = (cw.oe == OE_ALWAYS) || ((cw.oe == OE_WRAP) && wrap);
  assign go   = !emit || !out_vld_q || m_axis_tready_i;

  assign ram_we = accept && !is_delim && (wlen_q < LenW'(MaxWord));
  assign rd_idx = (cw.idx == IDX_INC) ? (go ? idx_q + LenW'(1) : idx_q) :
                  (cw.idx == IDX_CLEAR) ? '0 : idx_q;

  gww_ram #(
    .Width(CharW),
    .Depth(MaxWord)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wlen_q[AddrW-1:0]),
    .wdata_i(in_char),
    .raddr_i(rd_idx[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    pc_d       = pc_q;
    char_d     = char_q;
    wlen_d     = wlen_q;
    idx_d      = idx_q;
    in_word_d  = in_word_q;
    wleft_d    = wleft_q;
    out_vld_d  = out_vld_q;
    out_char_d = out_char_q;
    out_last_d = out_last_q;

    if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    if (go) begin
      if (emit) begin
        out_vld_d = 1'b1;
        unique case (cw.osel)
          OSEL_LETTER: out_char_d = ram_rdata;
          OSEL_SPACE:  out_char_d = CH_SP;
          default:     out_char_d = CH_NL;
        endcase
        unique case (cw.last)
          LAST_YES:       out_last_d = 1'b1;
          LAST_IF_NOT_NL: out_last_d = (char_q != CH_NL);
          default:        out_last_d = 1'b0;
        endcase
      end

      unique case (cw.wop)
        WOP_FIT:        wleft_d = wrap ? lw_ext - len_ext : wleft_q - len_p1;
        WOP_NUL_RELOAD: if (char_q == CH_NUL) wleft_d = lw_ext;
        WOP_RELOAD:     wleft_d = lw_ext;
        default:        ;
      endcase

      unique case (cw.idx)
        IDX_CLEAR: idx_d = '0;
        IDX_INC:   idx_d = idx_q + LenW'(1);
        default:   ;
      endcase

      if (cw.clr_word) begin
        wlen_d    = '0;
        in_word_d = 1'b0;
      end

      unique case (cw.br)
        BR_NEXT:       pc_d = pc_q + PcW'(1);
        BR_LOOP:       pc_d = (idx_q + LenW'(1) == wlen_q) ? pc_q + PcW'(1) : pc_q;
        BR_NL_OR_IDLE: pc_d = (char_q == CH_NL) ? pc_q + PcW'(1) : S_IDLE;
        BR_IDLE:       pc_d = S_IDLE;
        default: begin
          if (accept) begin
            char_d = in_char;
            if (!is_delim) begin
              in_word_d = 1'b1;
              if (ram_we) wlen_d = wlen_q + LenW'(1);
            end else if (in_word_q) begin
              pc_d = S_FIT;
            end else if (in_char == CH_NL) begin
              pc_d = S_NLOUT;
            end else if (in_char == CH_NUL) begin
              wleft_d = lw_ext;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= S_IDLE;
      wlen_q    <= '0;
      in_word_q <= 1'b0;
      wleft_q   <= $signed({{(WleftW-LineW){1'b0}}, RESET_WIDTH});
      lw_q      <= RESET_WIDTH;
      out_vld_q <= 1'b0;
    end else begin
      pc_q      <= pc_d;
      wlen_q    <= wlen_d;
      in_word_q <= in_word_d;
      wleft_q   <= wleft_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        lw_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    idx_q      <= idx_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_char_q};
  assign m_axis_tlast_o  = out_last_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wlen_q <= LenW'(MaxWord))
    else $error("word length above limit");

  a_word_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_word_q == (wlen_q != '0))
    else $error("word flag and length disagree");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == S_LETTERS) |-> (idx_q < wlen_q))
    else $error("letter index past word end");

  a_fit_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == S_FIT) |-> in_word_q)
    else $error("fit step without a word");

endmodule
